/* rtl/assert_macros.svh */
// Assertion macros used by the RTL of the plot sample packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define PSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/psp_pkg.sv */
// Types and constants of the plot sample packer.
`timescale 1ns / 1ps
package psp_pkg;

  localparam int LIMIT_W     = 31;
  localparam int SAMPLE_W    = 32;
  localparam int CHAN_W      = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int HDR_W       = 16;

  localparam logic [LIMIT_W-1:0] ONE_BYTE_LIMIT_RST = 31'd128;
  localparam logic [LIMIT_W-1:0] TWO_BYTE_LIMIT_RST = 31'd32768;

  localparam logic [CFG_INDEX_W-1:0] CFG_ONE_BYTE_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TWO_BYTE_LIMIT = 2'd1;

  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [1:0] {
    SZ_ABSENT = 2'd0,
    SZ_ONE    = 2'd1,
    SZ_TWO    = 2'd2,
    SZ_FOUR   = 2'd3
  } size_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EVAL,
    S_HDR_HI,
    S_HDR_LO,
    S_PAY_RD,
    S_PAY_OUT
  } state_t;

  typedef struct packed {
    logic                       kind;
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

endpackage

/* rtl/psp_classify.sv */
// Size classifier: picks the smallest byte count whose limit bounds a sample.
`timescale 1ns / 1ps
module psp_classify (
  input  logic signed [psp_pkg::SAMPLE_W-1:0] sample,
  input  logic [psp_pkg::LIMIT_W-1:0]         one_lim,
  input  logic [psp_pkg::LIMIT_W-1:0]         two_lim,
  output psp_pkg::size_code_t                 code
);

  logic signed [psp_pkg::SAMPLE_W:0] s_ext;
  logic signed [psp_pkg::SAMPLE_W:0] one_ext;
  logic signed [psp_pkg::SAMPLE_W:0] two_ext;
  logic                              fits_one;
  logic                              fits_two;

  assign s_ext   = {sample[psp_pkg::SAMPLE_W-1], sample};
  assign one_ext = $signed({2'b00, one_lim});
  assign two_ext = $signed({2'b00, two_lim});

  // Strict bound on both sides: -limit < s < limit.
  assign fits_one = (s_ext < one_ext) && (s_ext > -one_ext);
  assign fits_two = (s_ext < two_ext) && (s_ext > -two_ext);

  always_comb begin
    if (fits_one) begin
      code = psp_pkg::SZ_ONE;
    end else if (fits_two) begin
      code = psp_pkg::SZ_TWO;
    end else begin
      code = psp_pkg::SZ_FOUR;
    end
  end

endmodule

/* rtl/plot_sample_packer_core.sv */
// Top level of the plot sample packer: sample memory, packet sequencer, output register.
// Store: one store accepted per cycle while idle; writes the sample memory directly.
// Tick with active channels: a scan (read, then size each channel), then 3 to 34 bytes;
//   each active channel is read, then its bytes go one per cycle while out_stall is low.
// The scan and payload passes share the one read port of the sample memory.
// Reset (synchronous, rst_n low): clear active marks, sequencer, output valid; limits to
//   128 and 32768. Sample memory is not cleared; only entries marked active are used.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plot_sample_packer_core #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  psp_pkg::in_item_t                  in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output psp_pkg::out_item_t                 out_data,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [psp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [psp_pkg::LIMIT_W-1:0]        cfg_data
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Configuration registers
  logic [psp_pkg::LIMIT_W-1:0] one_lim_r;
  logic [psp_pkg::LIMIT_W-1:0] two_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_lim_r <= psp_pkg::ONE_BYTE_LIMIT_RST;
      two_lim_r <= psp_pkg::TWO_BYTE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psp_pkg::CFG_ONE_BYTE_LIMIT: one_lim_r <= cfg_data;
        psp_pkg::CFG_TWO_BYTE_LIMIT: two_lim_r <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Sample memory: one write port (stores), one registered read port (sequencer).
  // Stores are taken only in idle and reads happen only outside idle, so the two
  // never touch the same entry in one cycle; in_stall is the interlock.
  logic [psp_pkg::SAMPLE_W-1:0] mem [NUM_CHANNELS];
  logic [psp_pkg::SAMPLE_W-1:0] rd_data_r;
  logic                         wr_en;
  logic [CH_W-1:0]              wr_addr;
  logic                         rd_en;
  logic [CH_W-1:0]              rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.sample;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Sequencer state
  psp_pkg::state_t     state_r, state_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [1:0]          k_r, k_nxt;
  logic [NUM_CHANNELS-1:0] active_r, active_nxt;
  psp_pkg::size_code_t codes_r [NUM_CHANNELS];
  psp_pkg::size_code_t codes_nxt [NUM_CHANNELS];

  // Output register
  logic                out_valid_r;
  psp_pkg::out_item_t  out_data_r;
  logic                out_load;
  psp_pkg::out_item_t  out_item;
  logic                out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Size of the channel just read, against the current limits
  psp_pkg::size_code_t scan_code;

  psp_classify u_classify (
    .sample  ($signed(rd_data_r)),
    .one_lim (one_lim_r),
    .two_lim (two_lim_r),
    .code    (scan_code)
  );

  // Header: two bits per channel, channel c at bits 2c+1..2c
  logic [psp_pkg::HDR_W-1:0] header;

  always_comb begin
    header = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      header[2*i +: 2] = codes_r[i];
    end
  end

  // Next active channel: lowest active one, from zero when the payload starts,
  // otherwise above the current channel.
  logic            first_sel;
  logic            more_found;
  logic [CH_W-1:0] more_ch;

  assign first_sel = (state_r == psp_pkg::S_HDR_LO);

  always_comb begin
    more_found = 1'b0;
    more_ch    = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (active_r[i] && (first_sel || i > int'(ch_r))) begin
        more_found = 1'b1;
        more_ch    = CH_W'(i);
      end
    end
  end

  // Byte select for the payload: the final byte index follows the size code
  psp_pkg::size_code_t cur_code;
  logic [1:0]          last_k;
  logic [1:0]          shift_k;
  logic [7:0]          pay_byte;

  assign cur_code = codes_r[ch_r];

  always_comb begin
    case (cur_code)
      psp_pkg::SZ_TWO:  last_k = 2'd1;
      psp_pkg::SZ_FOUR: last_k = 2'd3;
      default:          last_k = 2'd0;
    endcase
  end

  assign shift_k = last_k - k_r;

  always_comb begin
    case (shift_k)
      2'd3:    pay_byte = rd_data_r[31:24];
      2'd2:    pay_byte = rd_data_r[23:16];
      2'd1:    pay_byte = rd_data_r[15:8];
      default: pay_byte = rd_data_r[7:0];
    endcase
  end

  assign in_stall = (state_r != psp_pkg::S_IDLE);

  // Next state and datapath control
  always_comb begin
    state_nxt  = state_r;
    ch_nxt     = ch_r;
    k_nxt      = k_r;
    active_nxt = active_r;
    codes_nxt  = codes_r;
    wr_en      = 1'b0;
    wr_addr    = in_data.channel[CH_W-1:0];
    rd_en      = 1'b0;
    rd_addr    = ch_r;
    out_load   = 1'b0;
    out_item   = '0;

    unique case (state_r)
      psp_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.kind == psp_pkg::KIND_STORE) begin
            // Drop stores to channels that do not exist
            if (32'(in_data.channel) < NUM_CHANNELS) begin
              wr_en = 1'b1;
              active_nxt[in_data.channel[CH_W-1:0]] = 1'b1;
            end
          end else if (active_r != '0) begin
            ch_nxt    = '0;
            state_nxt = psp_pkg::S_SCAN_RD;
          end
        end
      end

      psp_pkg::S_SCAN_RD: begin
        rd_en     = 1'b1;
        state_nxt = psp_pkg::S_SCAN_EVAL;
      end

      psp_pkg::S_SCAN_EVAL: begin
        codes_nxt[ch_r] = active_r[ch_r] ? scan_code : psp_pkg::SZ_ABSENT;
        if (ch_r == CH_W'(NUM_CHANNELS - 1)) begin
          state_nxt = psp_pkg::S_HDR_HI;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = psp_pkg::S_SCAN_RD;
        end
      end

      psp_pkg::S_HDR_HI: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_item.out_byte = header[15:8];
          state_nxt         = psp_pkg::S_HDR_LO;
        end
      end

      psp_pkg::S_HDR_LO: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_item.out_byte = header[7:0];
          ch_nxt            = more_ch;
          state_nxt         = psp_pkg::S_PAY_RD;
        end
      end

      psp_pkg::S_PAY_RD: begin
        rd_en     = 1'b1;
        k_nxt     = 2'd0;
        state_nxt = psp_pkg::S_PAY_OUT;
      end

      psp_pkg::S_PAY_OUT: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_item.out_byte = pay_byte;
          if (k_r == last_k) begin
            if (more_found) begin
              ch_nxt    = more_ch;
              state_nxt = psp_pkg::S_PAY_RD;
            end else begin
              out_item.last = 1'b1;
              state_nxt     = psp_pkg::S_IDLE;
            end
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end

      default: state_nxt = psp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= psp_pkg::S_IDLE;
      active_r <= '0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
    end
  end

  // Sequencer payload registers; only meaningful while a packet is formed
  always_ff @(posedge clk) begin
    ch_r    <= ch_nxt;
    k_r     <= k_nxt;
    codes_r <= codes_nxt;
  end

  // Hold the byte while the consumer stalls; advance when it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_item;
    end
  end

  // A packet is only formed while some channel is marked active
  `PSP_ASSERT_IMP(a_busy_has_active, state_r != psp_pkg::S_IDLE, active_r != '0)
  // Payload bytes come only from channels sized as present
  `PSP_ASSERT_IMP(a_pay_present, state_r == psp_pkg::S_PAY_OUT,
                  codes_r[ch_r] != psp_pkg::SZ_ABSENT)
  // A byte still pending while idle closes the previous packet
  `PSP_ASSERT_IMP(a_idle_pending_last, state_r == psp_pkg::S_IDLE && out_valid_r,
                  out_data_r.last)
  // A tick transfer with active channels starts the scan
  `PSP_ASSERT_NXT(a_tick_starts_scan,
                  in_valid && !in_stall && in_data.kind == psp_pkg::KIND_TICK &&
                  active_r != '0,
                  state_r == psp_pkg::S_SCAN_RD)

endmodule
